### hdl/dcs_pp_pkg.sv
// Package for the DCS write-memory pixel packer: command bytes, format and
// register index codes, limit constants and the result queue entry type.
// No dependencies.
package dcs_pp_pkg;

  localparam logic [7:0] CMD_START    = 8'h2C;
  localparam logic [7:0] CMD_CONTINUE = 8'h3C;

  localparam logic [1:0] FMT_RGB565   = 2'd0;
  localparam logic [1:0] FMT_RGB888   = 2'd1;
  localparam logic [1:0] FMT_XRGB8888 = 2'd2;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd1;
  localparam logic [1:0] REG_CHANNEL      = 2'd2;

  localparam int unsigned PAYLOAD_LIMIT_MAX = 1024;
  localparam int unsigned LIMIT_HARD_CAP    = 2046;
  localparam int unsigned LIMIT_CAP         =
      (PAYLOAD_LIMIT_MAX > LIMIT_HARD_CAP) ? LIMIT_HARD_CAP : PAYLOAD_LIMIT_MAX;
  localparam logic [10:0] LIMIT_CAP_V = 11'(LIMIT_CAP);
  localparam logic [10:0] LIMIT_MIN_V = 11'd5;
  localparam logic [10:0] LIMIT_RESET = 11'd1024;

  typedef struct packed {
    logic [31:0] payload_word;
    logic [2:0]  valid_bytes;
    logic        packet_end;
    logic [10:0] packet_length;
    logic        start_packet;
    logic [1:0]  virtual_channel;
  } out_entry_t;

endpackage

### hdl/dcs_memory_write_pixel_packer_unit.sv
// DCS write-memory pixel packer, top level.
// Uses dcs_pp_pkg for command bytes, codes, limits and the queue entry type.
//
// Usage: one pixel per input transfer (pixel_value_i, frame_end_i) on the
// in_valid_i / in_stall_o channel. Each pixel is packed into DCS long-write
// payload words, first byte in bits 7:0; each result word leaves as one
// transfer on out_valid_o / out_stall_i with its byte count, packet end flag,
// packet length, start flag and virtual channel. A pixel yields zero, one or
// two words. The first word of a packet carries the 0x2C or 0x3C command byte.
// A word is registered in the result queue on its pixel's transfer.
// Throughput: one pixel per cycle; the output side moves one word per cycle
// through a four-entry result queue, and in_stall_o rises while fewer than
// two entries are free. A stall on out_stall_i holds the head word and fills
// the queue, which then stalls the input.
// Configuration: writes on cfg_valid_i / cfg_ready_o are always taken and
// are expected only while the block is idle.
// Reset: queue empty, no packet open, next packet is a start packet,
// registers at RGB565, 1024-byte limit, channel 0.
module dcs_memory_write_pixel_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_value_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] payload_word_o,
  output logic [2:0]  valid_bytes_o,
  output logic        packet_end_o,
  output logic [10:0] packet_length_o,
  output logic        start_packet_o,
  output logic [1:0]  virtual_channel_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  // configuration registers
  logic [1:0]  fmt_q;
  logic [10:0] limit_q;
  logic [1:0]  chan_q;

  // packing state
  logic [23:0] held_q, held_d;
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [10:0] pbc_q, pbc_d;
  logic        fof_q, fof_d;

  // result queue
  dcs_pp_pkg::out_entry_t queue_q [QDEPTH];
  logic [QPW-1:0] rd_ptr_q, wr_ptr_q;
  logic [QPW:0]   count_q;

  logic        in_xfer, out_xfer;
  logic        bpp3;
  logic [2:0]  bpp;
  logic [23:0] base_acc, pix_seq;
  logic [1:0]  base_n;
  logic [10:0] base_pbc, pbc_new, lim;
  logic [47:0] acc48;
  logic [2:0]  n_tot, rem_n;
  logic [23:0] rem_acc;
  logic        full_word, close, tail_word;
  logic [1:0]  n_words;
  dcs_pp_pkg::out_entry_t ent0, ent1;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (count_q > (QPW+1)'(QDEPTH - 2));
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;

  always_comb begin
    bpp3 = (fmt_q != dcs_pp_pkg::FMT_RGB565);
    bpp  = bpp3 ? 3'd3 : 3'd2;

    // clamp the limit to [5, cap]
    lim = limit_q;
    if (lim > dcs_pp_pkg::LIMIT_CAP_V) lim = dcs_pp_pkg::LIMIT_CAP_V;
    if (lim < dcs_pp_pkg::LIMIT_MIN_V) lim = dcs_pp_pkg::LIMIT_MIN_V;

    if (pbc_q == '0) begin
      base_acc = {16'h0, fof_q ? dcs_pp_pkg::CMD_START : dcs_pp_pkg::CMD_CONTINUE};
      base_n   = 2'd1;
      base_pbc = 11'd1;
    end else begin
      base_acc = held_q;
      base_n   = held_cnt_q;
      base_pbc = pbc_q;
    end

    // significant bytes, most significant first, first byte lowest
    pix_seq = bpp3 ? {pixel_value_i[7:0], pixel_value_i[15:8], pixel_value_i[23:16]}
                   : {8'h0, pixel_value_i[7:0], pixel_value_i[15:8]};
    acc48   = {24'h0, base_acc} | ({24'h0, pix_seq} << {base_n, 3'b000});
    n_tot   = {1'b0, base_n} + bpp;
    pbc_new = base_pbc + {8'h0, bpp};
    close   = frame_end_i || (({1'b0, pbc_new} + {9'h0, bpp}) > {1'b0, lim});

    full_word = (n_tot >= 3'd4);
    if (full_word) begin
      rem_n   = n_tot - 3'd4;
      rem_acc = {8'h0, acc48[47:32]};
    end else begin
      rem_n   = n_tot;
      rem_acc = acc48[23:0];
    end
    tail_word = close && (rem_n != '0);
    n_words   = {1'b0, full_word} + {1'b0, tail_word};

    ent0.payload_word    = full_word ? acc48[31:0] : {8'h0, rem_acc};
    ent0.valid_bytes     = full_word ? 3'd4 : rem_n;
    ent0.packet_end      = close && !(full_word && tail_word);
    ent0.packet_length   = ent0.packet_end ? pbc_new : 11'd0;
    ent0.start_packet    = fof_q;
    ent0.virtual_channel = chan_q;

    ent1.payload_word    = {8'h0, rem_acc};
    ent1.valid_bytes     = rem_n;
    ent1.packet_end      = 1'b1;
    ent1.packet_length   = pbc_new;
    ent1.start_packet    = fof_q;
    ent1.virtual_channel = chan_q;

    held_d     = close ? 24'h0 : rem_acc;
    held_cnt_d = close ? 2'd0 : rem_n[1:0];
    pbc_d      = close ? 11'd0 : pbc_new;
    fof_d      = close ? frame_end_i : fof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= dcs_pp_pkg::FMT_RGB565;
      limit_q <= dcs_pp_pkg::LIMIT_RESET;
      chan_q  <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dcs_pp_pkg::REG_PIXEL_FORMAT: fmt_q   <= cfg_data_i[1:0];
        dcs_pp_pkg::REG_MAX_PAYLOAD:  limit_q <= cfg_data_i;
        dcs_pp_pkg::REG_CHANNEL:      chan_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_cnt_q <= '0;
      pbc_q      <= '0;
      fof_q      <= 1'b1;
    end else if (in_xfer) begin
      held_q     <= held_d;
      held_cnt_q <= held_cnt_d;
      pbc_q      <= pbc_d;
      fof_q      <= fof_d;
    end
  end

  // queue payload: write up to two entries per transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (n_words != 2'd0) queue_q[wr_ptr_q] <= ent0;
      if (n_words == 2'd2) queue_q[wr_ptr_q + QPW'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_xfer) wr_ptr_q <= wr_ptr_q + QPW'(n_words);
      if (out_xfer) rd_ptr_q <= rd_ptr_q + QPW'(1);
      count_q <= count_q + (in_xfer ? (QPW+1)'(n_words) : '0)
                         - (out_xfer ? (QPW+1)'(1) : '0);
    end
  end

  assign payload_word_o    = queue_q[rd_ptr_q].payload_word;
  assign valid_bytes_o     = queue_q[rd_ptr_q].valid_bytes;
  assign packet_end_o      = queue_q[rd_ptr_q].packet_end;
  assign packet_length_o   = queue_q[rd_ptr_q].packet_length;
  assign start_packet_o    = queue_q[rd_ptr_q].start_packet;
  assign virtual_channel_o = queue_q[rd_ptr_q].virtual_channel;

endmodule

### tb/sv/dcs_pp_word_checker.sv
// Scoreboard for the DCS write-memory pixel packer: tracks register writes,
// predicts the payload words of every accepted pixel and compares them with
// the block's output transfers. Depends on dcs_pp_pkg.
module dcs_pp_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] pixel_value_i,
  input  logic        frame_end_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] payload_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        packet_end_i,
  input  logic [10:0] packet_length_i,
  input  logic        start_packet_i,
  input  logic [1:0]  virtual_channel_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);
  import dcs_pp_pkg::*;

  // Register copies
  logic [1:0]  fmt_q;
  logic [10:0] limit_q;
  logic [1:0]  chan_q;

  // Packer state
  logic [23:0] held_bytes;
  logic [1:0]  held_count;
  logic [10:0] pkt_bytes;
  logic        first_of_frame;

  out_entry_t  expected_words[$];
  int unsigned n_errors = 0;
  int unsigned n_pending = 0;

  assign error_count_o = n_errors;
  assign pending_o     = n_pending;

  task automatic pack_pixel(input logic [31:0] pix, input logic fend);
    logic [63:0] acc;
    logic [7:0]  pix_byte;
    int unsigned n, bpp, lim, i, k;
    logic        close;
    out_entry_t  words[2];
    acc = {40'd0, held_bytes};
    n   = 32'(held_count);
    k   = 0;
    bpp = (fmt_q == FMT_RGB565) ? 2 : 3;
    lim = 32'(limit_q);
    if (lim > LIMIT_CAP) lim = LIMIT_CAP;
    if (lim < 32'(LIMIT_MIN_V)) lim = 32'(LIMIT_MIN_V);

    // open a packet with its command byte
    if (pkt_bytes == 11'd0) begin
      acc       = {56'd0, first_of_frame ? CMD_START : CMD_CONTINUE};
      n         = 1;
      pkt_bytes = 11'd1;
    end

    // most significant byte of the pixel goes first
    for (i = 0; i < bpp; i++) begin
      pix_byte = 8'(pix >> (8 * (bpp - 1 - i)));
      acc      = acc | (64'(pix_byte) << (8 * n));
      n++;
    end
    pkt_bytes = 11'(32'(pkt_bytes) + bpp);
    close     = fend || (32'(pkt_bytes) + bpp > lim);

    while (n >= 4) begin
      words[k] = '{payload_word: acc[31:0], valid_bytes: 3'd4, packet_end: 1'b0,
                   packet_length: 11'd0, start_packet: first_of_frame,
                   virtual_channel: chan_q};
      k++;
      acc = acc >> 32;
      n   = n - 4;
    end
    if (close && n > 0) begin
      words[k] = '{payload_word: acc[31:0], valid_bytes: 3'(n), packet_end: 1'b0,
                   packet_length: 11'd0, start_packet: first_of_frame,
                   virtual_channel: chan_q};
      k++;
      acc = '0;
      n   = 0;
    end
    if (close) begin
      words[k-1].packet_end    = 1'b1;
      words[k-1].packet_length = pkt_bytes;
      pkt_bytes      = 11'd0;
      first_of_frame = fend;
    end

    held_bytes = acc[23:0];
    held_count = 2'(n);
    for (i = 0; i < k; i++) expected_words.push_back(words[i]);
  endtask

  task automatic check_word(input out_entry_t got);
    out_entry_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected payload word %h", got.payload_word);
      n_errors++;
    end else begin
      want = expected_words.pop_front();
      if (got.payload_word !== want.payload_word) begin
        $error("payload_word: expected %h, got %h", want.payload_word, got.payload_word);
        n_errors++;
      end
      if (got.valid_bytes !== want.valid_bytes) begin
        $error("valid_bytes: expected %0d, got %0d", want.valid_bytes, got.valid_bytes);
        n_errors++;
      end
      if (got.packet_end !== want.packet_end) begin
        $error("packet_end: expected %0d, got %0d", want.packet_end, got.packet_end);
        n_errors++;
      end
      if (got.packet_length !== want.packet_length) begin
        $error("packet_length: expected %0d, got %0d", want.packet_length,
               got.packet_length);
        n_errors++;
      end
      if (got.start_packet !== want.start_packet) begin
        $error("start_packet: expected %0d, got %0d", want.start_packet, got.start_packet);
        n_errors++;
      end
      if (got.virtual_channel !== want.virtual_channel) begin
        $error("virtual_channel: expected %0d, got %0d", want.virtual_channel,
               got.virtual_channel);
        n_errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q          = FMT_RGB565;
      limit_q        = LIMIT_RESET;
      chan_q         = 2'd0;
      held_bytes     = '0;
      held_count     = '0;
      pkt_bytes      = '0;
      first_of_frame = 1'b1;
      expected_words.delete();
      n_pending      = 0;
    end else begin
      // a word leaving now belongs to an earlier pixel: retire before predicting
      if (out_valid_i && !out_stall_i) begin
        check_word('{payload_word: payload_word_i, valid_bytes: valid_bytes_i,
                     packet_end: packet_end_i, packet_length: packet_length_i,
                     start_packet: start_packet_i, virtual_channel: virtual_channel_i});
      end
      if (in_valid_i && !in_stall_i) pack_pixel(pixel_value_i, frame_end_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PIXEL_FORMAT: fmt_q   = cfg_data_i[1:0];
          REG_MAX_PAYLOAD:  limit_q = cfg_data_i;
          REG_CHANNEL:      chan_q  = cfg_data_i[1:0];
          default: ;
        endcase
      end
      n_pending = expected_words.size();
    end
  end

endmodule

### tb/sv/dcs_memory_write_pixel_packer_unit_tb.sv
// Testbench top for the DCS write-memory pixel packer: drives registers and
// pixels with random gaps and output stalls, and gives the verdict.
// Depends on dcs_pp_pkg, dcs_pp_word_checker and the block itself.
module dcs_memory_write_pixel_packer_unit_tb;
  import dcs_pp_pkg::*;

  localparam logic [1:0]  REG_UNUSED      = 2'd3;
  localparam logic [1:0]  FMT_UNUSED      = 2'd3;
  localparam int unsigned N_PHASES        = 12;
  localparam int unsigned ITEMS_PER_PHASE = 104;
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic        clk_i;
  logic        rst_n       = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [10:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic [31:0] pixel_value = '0;
  logic        frame_end   = 1'b0;
  logic        out_stall   = 1'b0;

  logic        cfg_ready;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] payload_word;
  logic [2:0]  valid_bytes;
  logic        packet_end;
  logic [10:0] packet_length;
  logic        start_packet;
  logic [1:0]  virtual_channel;

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_cycles   = 0;
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  logic        rx_hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  dcs_memory_write_pixel_packer_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pixel_value_i    (pixel_value),
    .frame_end_i      (frame_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .payload_word_o   (payload_word),
    .valid_bytes_o    (valid_bytes),
    .packet_end_o     (packet_end),
    .packet_length_o  (packet_length),
    .start_packet_o   (start_packet),
    .virtual_channel_o(virtual_channel)
  );

  dcs_pp_word_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_value_i    (pixel_value),
    .frame_end_i      (frame_end),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .payload_word_i   (payload_word),
    .valid_bytes_i    (valid_bytes),
    .packet_end_i     (packet_end),
    .packet_length_i  (packet_length),
    .start_packet_i   (start_packet),
    .virtual_channel_i(virtual_channel),
    .error_count_o    (n_errors),
    .pending_o        (n_pending)
  );

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("dcs_memory_write_pixel_packer_unit_tb: FAIL");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int unsigned hold_cnt;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall = 1'b1;
        for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      out_stall = rx_idle_en && ($urandom_range(0, 99) < 17);
    end
  end

  // Called at a falling edge; leaves valid high so back-to-back pixels stream
  task automatic send_pixel(input logic [31:0] pix, input logic fend);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < 17) begin
        in_valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid    = 1'b1;
    pixel_value = pix;
    frame_end   = fend;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Drain: a pixel may leave no word, so also idle past the last expected word
  task automatic settle();
    in_valid = 1'b0;
    wait (n_pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [10:0] pick_limit();
    case ($urandom_range(0, 11))
      0:       return LIMIT_MIN_V;
      1:       return LIMIT_CAP_V;
      2:       return 11'($urandom_range(0, 4));
      3:       return 11'($urandom_range(LIMIT_CAP + 1, 2047));
      default: return 11'($urandom_range(5, 48));
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase, k;
    repeat (12) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Reset settings: RGB565 frame of three pixels
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h8001_7FFE, 1'b1);
    settle();

    // Smallest limit: every pixel closes its own packet
    write_reg(REG_PIXEL_FORMAT, {9'h1FF, FMT_RGB888});
    write_reg(REG_MAX_PAYLOAD, LIMIT_MIN_V);
    write_reg(REG_CHANNEL, 11'h7FF);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h1234_5678, 1'b1);
    settle();

    // Packet full on the frame's last pixel, then a full start packet and a continue packet
    write_reg(REG_PIXEL_FORMAT, {9'h0AA, FMT_XRGB8888});
    write_reg(REG_MAX_PAYLOAD, 11'd7);
    write_reg(REG_CHANNEL, 11'd1);
    send_pixel(32'hA1B2_C3D4, 1'b0);
    send_pixel(32'h5E6F_7081, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h7F80_01FE, 1'b1);
    settle();

    // Unused format code and a limit below the floor
    write_reg(REG_PIXEL_FORMAT, {9'h000, FMT_UNUSED});
    write_reg(REG_MAX_PAYLOAD, 11'd0);
    send_pixel(32'hDEAD_BEEF, 1'b0);
    send_pixel(32'hC0FF_EE11, 1'b0);
    settle();

    // Limit above the cap, then settings change with a packet open
    write_reg(REG_PIXEL_FORMAT, {9'h000, FMT_RGB565});
    write_reg(REG_MAX_PAYLOAD, 11'h7FF);
    write_reg(REG_CHANNEL, 11'd2);
    send_pixel(32'h0102_0304, 1'b0);
    send_pixel(32'h0506_0708, 1'b0);
    send_pixel(32'h090A_0B0C, 1'b0);
    settle();
    write_reg(REG_MAX_PAYLOAD, LIMIT_MIN_V);
    write_reg(REG_PIXEL_FORMAT, {9'h000, FMT_RGB888});
    write_reg(REG_UNUSED, 11'h7FF);
    send_pixel(32'h55AA_33CC, 1'b0);
    send_pixel(32'h8877_6655, 1'b1);
    settle();

    for (phase = 0; phase < N_PHASES; phase++) begin
      tx_idle_en = (phase != 1);
      rx_idle_en = (phase != 1);
      write_reg(REG_PIXEL_FORMAT, {9'($urandom_range(0, 511)), 2'($urandom_range(0, 3))});
      write_reg(REG_MAX_PAYLOAD, pick_limit());
      write_reg(REG_CHANNEL, 11'($urandom_range(0, 2047)));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // fill the result queue until the input stalls
        if (phase == 3 && k == 20) rx_hold_req = 1'b1;
        if (phase == 5 && k == 50) begin
          in_valid = 1'b0;
          wait (n_pending == 0);
          @(negedge clk_i);
        end
        send_pixel(pick_pixel(), $urandom_range(0, 99) < 6);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (n_pending != 0) $error("%0d expected words never arrived", n_pending);
    if (n_errors == 0 && n_pending == 0) begin
      $display("dcs_memory_write_pixel_packer_unit_tb: PASS");
    end else begin
      $display("dcs_memory_write_pixel_packer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### dcs_memory_write_pixel_packer_unit.f
hdl/dcs_pp_pkg.sv
hdl/dcs_memory_write_pixel_packer_unit.sv
tb/sv/dcs_pp_word_checker.sv
tb/sv/dcs_memory_write_pixel_packer_unit_tb.sv
